FILE: hdl/arpc_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the ARP responder with its IPv4 to MAC cache.
// Used by the top level arp_responder_with_cache and by its testbench.
package arpc_pkg;

  // Cache geometry.
  localparam int unsigned CACHE_ENTRIES = 16;
  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);

  // Field widths.
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned ENTRY_W = IP_W + MAC_W;

  // Configuration port.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 64;
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  // Input commands.
  localparam logic [1:0] CMD_RECEIVE = 2'd0;
  localparam logic [1:0] CMD_SEND    = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;

  // Result outcomes.
  localparam logic [2:0] OUT_LEARNED = 3'd0;
  localparam logic [2:0] OUT_REPLY   = 3'd1;
  localparam logic [2:0] OUT_REQUEST = 3'd2;
  localparam logic [2:0] OUT_LOOKUP  = 3'd3;
  localparam logic [2:0] OUT_DROPPED = 3'd4;

  // ARP packet field values.
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [15:0] PKT_OP_REQ   = 16'd1;
  localparam logic [15:0] PKT_OP_REPLY = 16'd2;
  localparam logic [1:0]  ARP_OP_NONE  = 2'd0;
  localparam logic [1:0]  ARP_OP_REQ   = 2'd1;
  localparam logic [1:0]  ARP_OP_REPLY = 2'd2;

  localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

endpackage

FILE: hdl/arpc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Holds the cache entries; depends on nothing else.
module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/arp_responder_with_cache.sv
`timescale 1ns / 1ps
// ARP responder top level with its IPv4 to MAC cache.
// Depends on arpc_pkg and arpc_ram.
//
// One transaction is taken at a time; in_ready_o is high only while the
// sequencer is idle. A send command or a dropped packet goes from idle
// straight to the output state. A lookup or a learning packet scans the cache
// one entry per cycle through a single equality comparator behind the
// registered RAM read; a learning packet then passes through the write state.
// The scan stops early at a matching entry. A finished result sits in an
// output register, so the next transaction may be accepted while it waits.
// Cache entries have reset-cleared valid bits; no clearing pass is needed
// after reset.
module arp_responder_with_cache
  import arpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [15:0]         proto_type_i,
  input  logic [15:0]         opcode_i,
  input  logic [MAC_W-1:0]    sender_mac_i,
  input  logic [IP_W-1:0]     sender_ip_i,
  input  logic [IP_W-1:0]     target_ip_i,
  // Output channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          outcome_o,
  output logic [MAC_W-1:0]    eth_dest_mac_o,
  output logic [1:0]          arp_op_o,
  output logic [MAC_W-1:0]    frame_sender_mac_o,
  output logic [IP_W-1:0]     frame_sender_ip_o,
  output logic [MAC_W-1:0]    frame_target_mac_o,
  output logic [IP_W-1:0]     frame_target_ip_o,
  output logic                hit_o,
  output logic [MAC_W-1:0]    hit_mac_o,
  output logic                table_full_o
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

  // Configuration registers.
  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;

  // Control state.
  logic [1:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]         cmp_idx_q;
  logic                     match_q, match_d;
  logic [IDX_W-1:0]         match_idx_q;
  logic                     free_q, free_d;
  logic [IDX_W-1:0]         free_idx_q;
  logic                     full_q;
  logic [CACHE_ENTRIES-1:0] valid_q, valid_d;
  logic                     out_valid_q;

  // Latched transaction.
  logic [2:0]       kind_q;
  logic             learn_q;
  logic [IP_W-1:0]  key_q;
  logic [MAC_W-1:0] smac_q;
  logic [IP_W-1:0]  sip_q;
  logic [IP_W-1:0]  tip_q;
  logic [MAC_W-1:0] found_mac_q;

  // Result register.
  logic [2:0]       outcome_q;
  logic [MAC_W-1:0] eth_dest_q;
  logic [1:0]       arp_op_q;
  logic [MAC_W-1:0] fsmac_q;
  logic [IP_W-1:0]  fsip_q;
  logic [MAC_W-1:0] ftmac_q;
  logic [IP_W-1:0]  ftip_q;
  logic             hit_q;
  logic [MAC_W-1:0] hit_mac_q;
  logic             tfull_q;

  // RAM signals.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic in_fire;
  logic out_load;
  logic ip_eq;
  logic cmp_hit;
  logic cmp_free;
  logic scan_done;

  // Decode of a new transaction.
  logic       is_ipv4, for_us;
  logic [2:0] kind_new;
  logic       learn_new;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    is_ipv4   = (proto_type_i == PROTO_IPV4);
    for_us    = (target_ip_i == own_ip_q);
    kind_new  = OUT_DROPPED;
    learn_new = 1'b0;
    case (command_i)
      CMD_RECEIVE: begin
        if (is_ipv4 && for_us && opcode_i == PKT_OP_REQ) begin
          kind_new  = OUT_REPLY;
          learn_new = 1'b1;
        end else if ((is_ipv4 && opcode_i == PKT_OP_REQ) ||
                     (for_us && opcode_i == PKT_OP_REPLY)) begin
          kind_new  = OUT_LEARNED;
          learn_new = 1'b1;
        end
      end
      CMD_SEND:   kind_new = OUT_REQUEST;
      CMD_LOOKUP: kind_new = OUT_LOOKUP;
      default:    kind_new = OUT_DROPPED;
    endcase
  end

  // Configuration writes and reads; the register is picked by address bit 3.
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_OWN_MAC) ? APB_DW'(own_mac_q) : APB_DW'(own_ip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == REG_OWN_MAC) begin
        own_mac_q <= pwdata[MAC_W-1:0];
      end else begin
        own_ip_q <= pwdata[IP_W-1:0];
      end
    end
  end

  // Cache storage: {ip, mac} per entry.
  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Shared comparator on the entry read in the previous cycle.
  assign ip_eq     = (ram_rdata[ENTRY_W-1:MAC_W] == key_q);
  assign cmp_hit   = cmp_vld_q && valid_q[cmp_idx_q] && ip_eq;
  assign cmp_free  = cmp_vld_q && !valid_q[cmp_idx_q] && !free_q;
  assign scan_done = cmp_vld_q && (cmp_hit || cmp_idx_q == IDX_LAST);

  // Learning write, either a MAC update or a fill of the first free slot.
  assign ram_we    = (state_q == ST_WRITE) && (match_q || free_q);
  assign ram_waddr = match_q ? match_idx_q : free_idx_q;
  assign ram_wdata = {sip_q, smac_q};

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer next state.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmp_vld_d = 1'b0;
    match_d   = match_q;
    free_d    = free_q;
    valid_d   = valid_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          if (learn_new || kind_new == OUT_LOOKUP) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_hit) begin
          match_d = 1'b1;
        end
        if (cmp_free) begin
          free_d = 1'b1;
        end
        if (scan_done) begin
          state_d = learn_q ? ST_WRITE : ST_OUT;
        end else begin
          if (cnt_q < CNT_END) begin
            cnt_d     = cnt_q + CNT_W'(1);
            cmp_vld_d = 1'b1;
          end
        end
      end
      ST_WRITE: begin
        if (!match_q && free_q) begin
          valid_d[free_idx_q] = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      match_q   <= match_d;
      free_q    <= free_d;
      valid_q   <= valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction and scan payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cnt_q[IDX_W-1:0];
    if (in_fire) begin
      kind_q  <= kind_new;
      learn_q <= learn_new;
      key_q   <= (command_i == CMD_LOOKUP) ? target_ip_i : sender_ip_i;
      smac_q  <= sender_mac_i;
      sip_q   <= sender_ip_i;
      tip_q   <= target_ip_i;
    end
    if (state_q == ST_SCAN && cmp_hit) begin
      match_idx_q <= cmp_idx_q;
      found_mac_q <= ram_rdata[MAC_W-1:0];
    end
    if (state_q == ST_SCAN && cmp_free) begin
      free_idx_q <= cmp_idx_q;
    end
    if (state_q == ST_WRITE) begin
      full_q <= !match_q && !free_q;
    end else if (in_fire) begin
      full_q <= 1'b0;
    end
  end

  // Result register, loaded when it is empty or its result is taken in the same cycle.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      outcome_q <= kind_q;
      eth_dest_q <= '0;
      arp_op_q   <= ARP_OP_NONE;
      fsmac_q    <= '0;
      fsip_q     <= '0;
      ftmac_q    <= '0;
      ftip_q     <= '0;
      hit_q      <= 1'b0;
      hit_mac_q  <= '0;
      tfull_q    <= learn_q && full_q;
      case (kind_q)
        OUT_REPLY: begin
          eth_dest_q <= smac_q;
          arp_op_q   <= ARP_OP_REPLY;
          fsmac_q    <= own_mac_q;
          fsip_q     <= tip_q;
          ftmac_q    <= smac_q;
          ftip_q     <= sip_q;
        end
        OUT_REQUEST: begin
          eth_dest_q <= MAC_BROADCAST;
          arp_op_q   <= ARP_OP_REQ;
          fsmac_q    <= own_mac_q;
          fsip_q     <= own_ip_q;
          ftip_q     <= tip_q;
        end
        OUT_LOOKUP: begin
          hit_q     <= match_q;
          hit_mac_q <= match_q ? found_mac_q : '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = outcome_q;
  assign eth_dest_mac_o     = eth_dest_q;
  assign arp_op_o           = arp_op_q;
  assign frame_sender_mac_o = fsmac_q;
  assign frame_sender_ip_o  = fsip_q;
  assign frame_target_mac_o = ftmac_q;
  assign frame_target_ip_o  = ftip_q;
  assign hit_o              = hit_q;
  assign hit_mac_o          = hit_mac_q;
  assign table_full_o       = tfull_q;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for arp_responder_with_cache: directed and random ARP
// commands against a cycle-free predictor of the responder and its cache.
// Depends on arpc_pkg and the arp_responder_with_cache RTL.
module testbench
  import arpc_pkg::*;
();

  // Command value that the block does not define; it must be dropped.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  // Register byte addresses: the MAC register is wider than 32 bits, so the
  // registers sit on 8-byte boundaries.
  localparam logic [APB_AW-1:0] ADDR_OWN_IP  = APB_AW'({REG_OWN_IP, 3'b000});
  localparam logic [APB_AW-1:0] ADDR_OWN_MAC = APB_AW'({REG_OWN_MAC, 3'b000});

  localparam int unsigned POOL_SIZE      = 24;
  localparam int unsigned PHASES         = 4;
  localparam int unsigned ITEMS_PER_PHASE = 420;
  localparam int unsigned HOLD_CYCLES    = 80;

  typedef struct packed {
    logic [1:0]       command;
    logic [15:0]      proto_type;
    logic [15:0]      opcode;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
  } arp_item_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic [MAC_W-1:0] eth_dest_mac;
    logic [1:0]       arp_op;
    logic [MAC_W-1:0] frame_sender_mac;
    logic [IP_W-1:0]  frame_sender_ip;
    logic [MAC_W-1:0] frame_target_mac;
    logic [IP_W-1:0]  frame_target_ip;
    logic             hit;
    logic [MAC_W-1:0] hit_mac;
    logic             table_full;
  } arp_result_t;

  // Predicts the result of each accepted command from its own copy of the
  // registers and the cache, and checks the results in order.
  class arp_result_book;
    logic [IP_W-1:0]  own_ip;
    logic [MAC_W-1:0] own_mac;
    bit               slot_used[CACHE_ENTRIES];
    logic [IP_W-1:0]  slot_ip[CACHE_ENTRIES];
    logic [MAC_W-1:0] slot_mac[CACHE_ENTRIES];
    arp_result_t      expected_results[$];
    int unsigned      mismatches;

    function new();
      own_ip = '0;
      own_mac = '0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      if (addr == ADDR_OWN_IP) begin
        own_ip = data[IP_W-1:0];
      end else if (addr == ADDR_OWN_MAC) begin
        own_mac = data[MAC_W-1:0];
      end
    endfunction

    function int find_slot(logic [IP_W-1:0] ip);
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (slot_used[i] && slot_ip[i] == ip) return i;
      end
      return -1;
    endfunction

    // Updates a known sender or takes the lowest free slot; returns 1 when
    // the cache is full and nothing was learned.
    function bit learn_sender(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
      int idx;
      idx = find_slot(ip);
      if (idx >= 0) begin
        slot_mac[idx] = mac;
        return 1'b0;
      end
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          slot_ip[i] = ip;
          slot_mac[i] = mac;
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_command(arp_item_t it);
      arp_result_t r;
      bit          is_ipv4;
      bit          for_us;
      int          idx;
      r = '0;
      is_ipv4 = (it.proto_type == PROTO_IPV4);
      for_us = (it.target_ip == own_ip);
      case (it.command)
        CMD_RECEIVE: begin
          if (is_ipv4 && for_us && it.opcode == PKT_OP_REQ) begin
            r.table_full = learn_sender(it.sender_ip, it.sender_mac);
            r.outcome = OUT_REPLY;
            r.eth_dest_mac = it.sender_mac;
            r.arp_op = ARP_OP_REPLY;
            r.frame_sender_mac = own_mac;
            r.frame_sender_ip = it.target_ip;
            r.frame_target_mac = it.sender_mac;
            r.frame_target_ip = it.sender_ip;
          end else if ((is_ipv4 && it.opcode == PKT_OP_REQ) ||
                       (for_us && it.opcode == PKT_OP_REPLY)) begin
            r.table_full = learn_sender(it.sender_ip, it.sender_mac);
            r.outcome = OUT_LEARNED;
          end else begin
            r.outcome = OUT_DROPPED;
          end
        end
        CMD_SEND: begin
          r.outcome = OUT_REQUEST;
          r.eth_dest_mac = MAC_BROADCAST;
          r.arp_op = ARP_OP_REQ;
          r.frame_sender_mac = own_mac;
          r.frame_sender_ip = own_ip;
          r.frame_target_ip = it.target_ip;
        end
        CMD_LOOKUP: begin
          idx = find_slot(it.target_ip);
          r.outcome = OUT_LOOKUP;
          if (idx >= 0) begin
            r.hit = 1'b1;
            r.hit_mac = slot_mac[idx];
          end
        end
        default: r.outcome = OUT_DROPPED;
      endcase
      expected_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch in %s: expected %h, got %h", $realtime, field, want, got);
      end
    endfunction

    function void check_result(arp_result_t got);
      arp_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with outcome %0d arrived with nothing expected",
                   $realtime, got.outcome);
        return;
      end
      want = expected_results.pop_front();
      compare_field("outcome", want.outcome, got.outcome);
      compare_field("eth_dest_mac", want.eth_dest_mac, got.eth_dest_mac);
      compare_field("arp_op", want.arp_op, got.arp_op);
      compare_field("frame_sender_mac", want.frame_sender_mac, got.frame_sender_mac);
      compare_field("frame_sender_ip", want.frame_sender_ip, got.frame_sender_ip);
      compare_field("frame_target_mac", want.frame_target_mac, got.frame_target_mac);
      compare_field("frame_target_ip", want.frame_target_ip, got.frame_target_ip);
      compare_field("hit", want.hit, got.hit);
      compare_field("hit_mac", want.hit_mac, got.hit_mac);
      compare_field("table_full", want.table_full, got.table_full);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        command_i;
  logic [15:0]       proto_type_i;
  logic [15:0]       opcode_i;
  logic [MAC_W-1:0]  sender_mac_i;
  logic [IP_W-1:0]   sender_ip_i;
  logic [IP_W-1:0]   target_ip_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [2:0]        outcome_o;
  logic [MAC_W-1:0]  eth_dest_mac_o;
  logic [1:0]        arp_op_o;
  logic [MAC_W-1:0]  frame_sender_mac_o;
  logic [IP_W-1:0]   frame_sender_ip_o;
  logic [MAC_W-1:0]  frame_target_mac_o;
  logic [IP_W-1:0]   frame_target_ip_o;
  logic              hit_o;
  logic [MAC_W-1:0]  hit_mac_o;
  logic              table_full_o;

  arp_result_book book = new();
  logic [IP_W-1:0] ip_pool[POOL_SIZE];
  bit              idle_enable = 1'b1;
  // Bumped by the stimulus to ask the result side for one long hold-off.
  int unsigned     hold_count = 0;

  arp_responder_with_cache dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .proto_type_i       (proto_type_i),
    .opcode_i           (opcode_i),
    .sender_mac_i       (sender_mac_i),
    .sender_ip_i        (sender_ip_i),
    .target_ip_i        (target_ip_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .outcome_o          (outcome_o),
    .eth_dest_mac_o     (eth_dest_mac_o),
    .arp_op_o           (arp_op_o),
    .frame_sender_mac_o (frame_sender_mac_o),
    .frame_sender_ip_o  (frame_sender_ip_o),
    .frame_target_mac_o (frame_target_mac_o),
    .frame_target_ip_o  (frame_target_ip_o),
    .hit_o              (hit_o),
    .hit_mac_o          (hit_mac_o),
    .table_full_o       (table_full_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is bounded well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: check each accepted transaction, then pick the next ready
  // level from random stall bursts or a requested long hold-off.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned holds_taken;
    logic        ready_next;
    hold_left = 0;
    stall_left = 0;
    holds_taken = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        book.check_result({outcome_o, eth_dest_mac_o, arp_op_o, frame_sender_mac_o,
                           frame_sender_ip_o, frame_target_mac_o, frame_target_ip_o,
                           hit_o, hit_mac_o, table_full_o});
      end
      if (hold_count != holds_taken) begin
        holds_taken = hold_count;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready_i <= ready_next;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly addresses from a small pool so that lookups hit and senders repeat.
  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(0, 9) < 7) return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic arp_item_t pkt(logic [1:0] cmd, logic [15:0] proto, logic [15:0] op,
                                    logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                                    logic [IP_W-1:0] tip);
    arp_item_t it;
    it.command = cmd;
    it.proto_type = proto;
    it.opcode = op;
    it.sender_mac = smac;
    it.sender_ip = sip;
    it.target_ip = tip;
    return it;
  endfunction

  // Mostly well-formed ARP traffic with random content, plus some noise.
  function automatic arp_item_t random_item();
    arp_item_t   it;
    int unsigned pick;
    it = pkt(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), rand_mac(),
             $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.command = CMD_RECEIVE;
      if ($urandom_range(0, 9) != 0) it.proto_type = PROTO_IPV4;
      if ($urandom_range(0, 9) != 0)
        it.opcode = $urandom_range(0, 1) ? PKT_OP_REQ : PKT_OP_REPLY;
      it.sender_ip = pick_ip();
      it.target_ip = $urandom_range(0, 1) ? book.own_ip : pick_ip();
    end else if (pick < 65) begin
      it.command = CMD_SEND;
      it.target_ip = pick_ip();
    end else if (pick < 90) begin
      it.command = CMD_LOOKUP;
      it.target_ip = pick_ip();
    end else if (pick < 95) begin
      it.command = CMD_UNKNOWN;
    end
    return it;
  endfunction

  task automatic send_item(input arp_item_t it);
    command_i <= it.command;
    proto_type_i <= it.proto_type;
    opcode_i <= it.opcode;
    sender_mac_i <= it.sender_mac;
    sender_ip_i <= it.sender_ip;
    target_ip_i <= it.target_ip;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_command(it);
  endtask

  // Random idle burst on the command side.
  task automatic sender_gap();
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Stop offering commands until every expected result has been taken.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  // A setup phase and then an access phase; psel stays high so writes can chain.
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    book.write_reg(addr, data);
  endtask

  task automatic configure(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
    apb_write(ADDR_OWN_IP, APB_DW'(ip));
    apb_write(ADDR_OWN_MAC, APB_DW'(mac));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    logic [IP_W-1:0]  me;
    logic [IP_W-1:0]  ip_x;
    logic [IP_W-1:0]  ip_y;
    logic [IP_W-1:0]  ip_z;
    arp_item_t        directed[$];
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    command_i <= CMD_RECEIVE;
    proto_type_i <= '0;
    opcode_i <= '0;
    sender_mac_i <= '0;
    sender_ip_i <= '0;
    target_ip_i <= '0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every command, learning paths, drops and field extremes.
    configure($urandom, rand_mac());
    me = book.own_ip;
    ip_x = ip_pool[0];
    ip_y = ip_pool[1];
    ip_z = ip_pool[2];
    directed.push_back(pkt(CMD_LOOKUP, '0, '0, '0, '0, ip_x));
    directed.push_back(pkt(CMD_RECEIVE, PROTO_IPV4, PKT_OP_REQ, rand_mac(), ip_x, me));
    directed.push_back(pkt(CMD_LOOKUP, '0, '0, '0, '0, ip_x));
    directed.push_back(pkt(CMD_RECEIVE, PROTO_IPV4, PKT_OP_REQ, rand_mac(), ip_x, me));
    directed.push_back(pkt(CMD_LOOKUP, '0, '0, '0, '0, ip_x));
    directed.push_back(pkt(CMD_RECEIVE, PROTO_IPV4, PKT_OP_REQ, rand_mac(), ip_y, ip_z));
    // A reply aimed at us is learned whatever its protocol type.
    directed.push_back(pkt(CMD_RECEIVE, 16'hFFFF, PKT_OP_REPLY, rand_mac(), ip_z, me));
    directed.push_back(pkt(CMD_LOOKUP, '0, '0, '0, '0, ip_z));
    directed.push_back(pkt(CMD_RECEIVE, PROTO_IPV4, PKT_OP_REPLY, rand_mac(), ip_y, ip_z));
    directed.push_back(pkt(CMD_RECEIVE, 16'h86DD, PKT_OP_REQ, rand_mac(), ip_y, me));
    directed.push_back(pkt(CMD_RECEIVE, PROTO_IPV4, 16'h0000, rand_mac(), ip_y, me));
    directed.push_back(pkt(CMD_RECEIVE, PROTO_IPV4, 16'hFFFF, rand_mac(), ip_y, me));
    directed.push_back(pkt(CMD_SEND, '0, '0, '0, '0, '0));
    directed.push_back(pkt(CMD_SEND, '1, '1, '1, '1, '1));
    directed.push_back(pkt(CMD_UNKNOWN, '1, '1, '1, '1, '1));
    directed.push_back(pkt(CMD_RECEIVE, '0, '0, '0, '0, '0));
    directed.push_back(pkt(CMD_RECEIVE, '1, '1, '1, '1, '1));
    directed.push_back(pkt(CMD_RECEIVE, PROTO_IPV4, PKT_OP_REQ, '1, '1, ip_z));
    directed.push_back(pkt(CMD_LOOKUP, '0, '0, '0, '0, '1));
    directed.push_back(pkt(CMD_RECEIVE, PROTO_IPV4, PKT_OP_REQ, '0, '0, ip_z));
    directed.push_back(pkt(CMD_LOOKUP, '1, '1, '1, '1, '0));
    foreach (directed[i]) begin
      send_item(directed[i]);
      sender_gap();
    end

    // Random phases, each under its own register setting; the last one runs
    // without any idling on either side.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_all_results();
      case (phase)
        0: configure('1, '1);
        1: configure('0, '0);
        default: configure($urandom, rand_mac());
      endcase
      idle_enable = (phase != PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 1 && n == 200) wait_all_results();
        if (phase == 2 && n == 100) hold_count++;
        send_item(random_item());
        sender_gap();
      end
    end

    wait_all_results();
    repeat (25) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
